[design/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared constants, event types and character helpers for the chunked body
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

   localparam int MAX_HEX_DIGITS = 16;
   localparam int HEX_LEN_W      = $clog2(MAX_HEX_DIGITS + 1);
   localparam int HEX_IDX_W      = $clog2(MAX_HEX_DIGITS);

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_LF     = 8'd10;
   localparam logic [7:0] CASE_MASK   = 8'hDF;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_F      = 8'h46;
   localparam logic [3:0] LETTER_BIAS = 4'd9;

   typedef enum logic [1:0] {
      EV_PUSH,
      EV_DROP,
      EV_FINISH,
      EV_FLUSH
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type kind;
      logic [7:0]  data;
      logic        last;
   } ev_type;

   function automatic logic is_hex_digit(input logic [7:0] c);
      logic [7:0] u;
      u = c & CASE_MASK;
      return ((c >= CHAR_0) && (c <= CHAR_9)) || ((u >= CHAR_A) && (u <= CHAR_F));
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      if ((c >= CHAR_0) && (c <= CHAR_9)) begin
         return c[3:0];
      end
      return {1'b0, c[2:0]} + LETTER_BIAS;
   endfunction

endpackage

`default_nettype wire

[design/http_chunked_body_decoder.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Strips chunk-size lines from a received HTTP byte stream.
//
// Input channel (req_): one received byte per transaction in req_tdata;
// req_tlast marks end of input, which flushes the held bytes and any pending
// hex digits, then returns the decoder to its reset state.
// Result channel (rsp_): one body byte or status per transaction; rsp_tlast
// marks the final result caused by an input transaction.
// A line parser takes one byte per cycle while it is not replaying digits and
// the queue has room, and issues events into a four-entry queue; a holdback
// stage keeps the last two kept bytes and feeds a single output register. A
// kept byte leaves two kept bytes later; the first result of a transaction
// passes through the queue and the output register. Throughput is one byte
// per cycle under those conditions. A hex line that turns out to be text, or
// end of input with pending digits, holds the input while the stored digits
// are replayed; an end-of-input flush of two held bytes sends them in turn.
// Reset clears all control state; no result is valid after reset.
// When the receiver stalls, the output register holds, the queue fills and
// req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] in_byte
   input  wire         req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // last_of_run
   output logic [1:0]  rsp_tuser    // [0] finished, [1] byte_valid
);

   logic             fe_valid;
   hcbd_pkg::ev_type fe_ev;
   logic             q_ready;
   logic             q_valid;
   hcbd_pkg::ev_type q_ev;
   logic             q_pop;

   hcbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .ev_valid   (fe_valid),
      .ev         (fe_ev),
      .q_ready    (q_ready)
   );

   hcbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ev     (fe_ev),
      .in_ready  (q_ready),
      .out_valid (q_valid),
      .out_ev    (q_ev),
      .out_pop   (q_pop)
   );

   hcbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .ev_valid   (q_valid),
      .ev         (q_ev),
      .ev_pop     (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

[design/hcbd_front.sv]
// ----------------------------------------------------------------------------
// hcbd_front
// Accepts stream bytes, tracks chunk-size lines and issues holdback events.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire  [7:0]          req_tdata,
   input  wire                 req_tlast,
   output logic                ev_valid,
   output hcbd_pkg::ev_type    ev,
   input  wire                 q_ready
);

   typedef enum logic [1:0] {
      MODE_SCAN,
      MODE_SKIP,
      MODE_PASS,
      MODE_DONE
   } mode_type;

   mode_type                        mode_ff, mode_in;
   logic [31:0]                     chunk_ff, chunk_in;
   logic [31:0]                     accum_ff, accum_in;
   logic [hcbd_pkg::HEX_LEN_W-1:0]  hex_len_ff, hex_len_in;
   logic                            plain_ff, plain_in;
   logic                            spill_on_ff, spill_on_in;
   logic [hcbd_pkg::HEX_LEN_W-1:0]  spill_idx_ff, spill_idx_in;
   logic [hcbd_pkg::HEX_LEN_W-1:0]  spill_len_ff, spill_len_in;
   logic                            tail_flush_ff, tail_flush_in;
   logic [7:0]                      tail_byte_ff, tail_byte_in;
   logic [7:0]                      store_ff [hcbd_pkg::MAX_HEX_DIGITS];
   logic                            store_we;
   logic                            accept;
   logic                            is_eol;
   logic                            is_hex;
   logic [3:0]                      digit;

   assign is_eol = (req_tdata == hcbd_pkg::CHAR_CR) || (req_tdata == hcbd_pkg::CHAR_LF);
   assign is_hex = hcbd_pkg::is_hex_digit(req_tdata);
   assign digit  = hcbd_pkg::hex_value(req_tdata);

   always_comb begin
      mode_in       = mode_ff;
      chunk_in      = chunk_ff;
      accum_in      = accum_ff;
      hex_len_in    = hex_len_ff;
      plain_in      = plain_ff;
      spill_on_in   = spill_on_ff;
      spill_idx_in  = spill_idx_ff;
      spill_len_in  = spill_len_ff;
      tail_flush_in = tail_flush_ff;
      tail_byte_in  = tail_byte_ff;
      store_we      = 1'b0;
      ev_valid      = 1'b0;
      ev.kind       = hcbd_pkg::EV_PUSH;
      ev.data       = req_tdata;
      ev.last       = 1'b1;
      req_tready    = !spill_on_ff && q_ready;
      accept        = req_tvalid && req_tready;

      if (spill_on_ff) begin
         if (q_ready) begin
            ev_valid = 1'b1;
            if (spill_idx_ff < spill_len_ff) begin
               ev.data      = store_ff[spill_idx_ff[hcbd_pkg::HEX_IDX_W-1:0]];
               ev.last      = 1'b0;
               spill_idx_in = spill_idx_ff + 1'b1;
            end else begin
               ev.kind     = tail_flush_ff ? hcbd_pkg::EV_FLUSH : hcbd_pkg::EV_PUSH;
               ev.data     = tail_byte_ff;
               spill_on_in = 1'b0;
            end
         end
      end else if (accept) begin
         if (req_tlast) begin
            if ((mode_ff == MODE_SCAN) && (hex_len_ff != '0)) begin
               spill_on_in   = 1'b1;
               spill_idx_in  = '0;
               spill_len_in  = hex_len_ff;
               tail_flush_in = 1'b1;
            end else begin
               ev_valid = 1'b1;
               ev.kind  = hcbd_pkg::EV_FLUSH;
            end
            mode_in    = MODE_SCAN;
            chunk_in   = '0;
            accum_in   = '0;
            hex_len_in = '0;
            plain_in   = 1'b0;
         end else begin
            unique case (mode_ff)
               MODE_DONE: begin
               end
               MODE_SKIP: begin
                  mode_in    = (chunk_ff != '0) ? MODE_PASS : MODE_SCAN;
                  accum_in   = '0;
                  hex_len_in = '0;
                  plain_in   = 1'b0;
               end
               MODE_PASS: begin
                  ev_valid = 1'b1;
                  chunk_in = chunk_ff - 32'd1;
                  if (chunk_ff == 32'd1) begin
                     mode_in    = MODE_SCAN;
                     accum_in   = '0;
                     hex_len_in = '0;
                     plain_in   = 1'b0;
                  end
               end
               MODE_SCAN: begin
                  if (is_eol) begin
                     ev_valid = 1'b1;
                     if ((hex_len_ff != '0) && !plain_ff) begin
                        if (accum_ff != '0) begin
                           ev.kind  = hcbd_pkg::EV_DROP;
                           chunk_in = accum_ff;
                           mode_in  = MODE_SKIP;
                        end else begin
                           ev.kind = hcbd_pkg::EV_FINISH;
                           mode_in = MODE_DONE;
                        end
                     end
                     accum_in   = '0;
                     hex_len_in = '0;
                     plain_in   = 1'b0;
                  end else if (plain_ff) begin
                     ev_valid = 1'b1;
                  end else if (is_hex &&
                               (hex_len_ff < hcbd_pkg::HEX_LEN_W'(hcbd_pkg::MAX_HEX_DIGITS)))
                  begin
                     store_we   = 1'b1;
                     hex_len_in = hex_len_ff + 1'b1;
                     accum_in   = {accum_ff[27:0], digit};
                  end else begin
                     if (hex_len_ff != '0) begin
                        spill_on_in   = 1'b1;
                        spill_idx_in  = '0;
                        spill_len_in  = hex_len_ff;
                        tail_flush_in = 1'b0;
                        tail_byte_in  = req_tdata;
                     end else begin
                        ev_valid = 1'b1;
                     end
                     plain_in   = 1'b1;
                     accum_in   = '0;
                     hex_len_in = '0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_SCAN;
         chunk_ff      <= '0;
         accum_ff      <= '0;
         hex_len_ff    <= '0;
         plain_ff      <= 1'b0;
         spill_on_ff   <= 1'b0;
         spill_idx_ff  <= '0;
         spill_len_ff  <= '0;
         tail_flush_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         chunk_ff      <= chunk_in;
         accum_ff      <= accum_in;
         hex_len_ff    <= hex_len_in;
         plain_ff      <= plain_in;
         spill_on_ff   <= spill_on_in;
         spill_idx_ff  <= spill_idx_in;
         spill_len_ff  <= spill_len_in;
         tail_flush_ff <= tail_flush_in;
      end
      tail_byte_ff <= tail_byte_in;
      if (store_we) begin
         store_ff[hex_len_ff[hcbd_pkg::HEX_IDX_W-1:0]] <= req_tdata;
      end
   end

endmodule

`default_nettype wire

[design/hcbd_queue.sv]
// ----------------------------------------------------------------------------
// hcbd_queue
// Short event queue between the line parser and the holdback stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   input  hcbd_pkg::ev_type    in_ev,
   output logic                in_ready,
   output logic                out_valid,
   output hcbd_pkg::ev_type    out_ev,
   input  wire                 out_pop
);

   hcbd_pkg::ev_type                  entry_ff [hcbd_pkg::QUEUE_DEPTH];
   logic [hcbd_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [hcbd_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [hcbd_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                              push;
   logic                              pop;

   assign in_ready  = (count_ff != hcbd_pkg::QUEUE_CNT_W'(hcbd_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_ev    = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_ev;
      end
   end

endmodule

`default_nettype wire

[design/hcbd_back.sv]
// ----------------------------------------------------------------------------
// hcbd_back
// Two-byte holdback and output register; carries out queued events.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 ev_valid,
   input  hcbd_pkg::ev_type    ev,
   output logic                ev_pop,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic [1:0]          rsp_tuser
);

   logic [7:0] hold0_ff, hold0_in;
   logic [7:0] hold1_ff, hold1_in;
   logic [1:0] count_ff, count_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_fin_ff, rsp_fin_in;
   logic       rsp_bval_ff, rsp_bval_in;
   logic       out_free;
   logic       load;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_bval_ff, rsp_fin_ff};

   always_comb begin
      hold0_in    = hold0_ff;
      hold1_in    = hold1_ff;
      count_in    = count_ff;
      ev_pop      = 1'b0;
      load        = 1'b0;
      rsp_byte_in = hold0_ff;
      rsp_last_in = ev.last;
      rsp_fin_in  = 1'b0;
      rsp_bval_in = 1'b1;

      if (ev_valid) begin
         unique case (ev.kind)
            hcbd_pkg::EV_PUSH: begin
               if (count_ff == 2'd2) begin
                  if (out_free) begin
                     load     = 1'b1;
                     hold0_in = hold1_ff;
                     hold1_in = ev.data;
                     ev_pop   = 1'b1;
                  end
               end else begin
                  if (count_ff == 2'd0) begin
                     hold0_in = ev.data;
                  end else begin
                     hold1_in = ev.data;
                  end
                  count_in = count_ff + 2'd1;
                  ev_pop   = 1'b1;
               end
            end
            hcbd_pkg::EV_DROP: begin
               count_in = 2'd0;
               ev_pop   = 1'b1;
            end
            hcbd_pkg::EV_FINISH: begin
               if (out_free) begin
                  load        = 1'b1;
                  rsp_byte_in = 8'd0;
                  rsp_last_in = 1'b1;
                  rsp_fin_in  = 1'b1;
                  rsp_bval_in = 1'b0;
                  count_in    = 2'd0;
                  ev_pop      = 1'b1;
               end
            end
            hcbd_pkg::EV_FLUSH: begin
               if (count_ff == 2'd0) begin
                  ev_pop = 1'b1;
               end else if (out_free) begin
                  load = 1'b1;
                  if (count_ff == 2'd1) begin
                     rsp_last_in = 1'b1;
                     count_in    = 2'd0;
                     ev_pop      = 1'b1;
                  end else begin
                     rsp_last_in = 1'b0;
                     hold0_in    = hold1_ff;
                     count_in    = 2'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold0_ff <= hold0_in;
      hold1_ff <= hold1_in;
      if (load) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
         rsp_fin_ff  <= rsp_fin_in;
         rsp_bval_ff <= rsp_bval_in;
      end
   end

endmodule

`default_nettype wire

[tb/http_chunked_body_decoder_checker.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_checker
// Watches both streams of the chunked body decoder, predicts the body bytes
// and status results each accepted input byte produces, and compares every
// accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   input  wire        req_tready,
   input  wire  [7:0] req_tdata,
   input  wire        req_tlast,
   input  wire        rsp_tvalid,
   input  wire        rsp_tready,
   input  wire  [7:0] rsp_tdata,
   input  wire        rsp_tlast,
   input  wire  [1:0] rsp_tuser,
   output int         expected_left,
   output int         mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIGIT_SLOTS = hcbd_pkg::MAX_HEX_DIGITS;

   typedef enum logic [1:0] {
      LINE_SCAN,
      SKIP_ONE,
      CHUNK_PASS,
      BODY_DONE
   } parse_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       finished;
      logic       has_byte;
   } body_result_type;

   body_result_type body_expected[$];

   parse_mode_type mode;
   logic [31:0]    chunk_left;
   logic [31:0]    size_acc;
   int             digit_count;
   logic           plain_line;
   logic [7:0]     digit_store [DIGIT_SLOTS];
   logic [7:0]     held [2];
   int             held_count;
   int             fail_total = 0;

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) begin
         return int'(c) - 'h30;
      end
      if (c >= 8'h61 && c <= 8'h66) begin
         return int'(c) - 'h61 + 10;
      end
      if (c >= 8'h41 && c <= 8'h46) begin
         return int'(c) - 'h41 + 10;
      end
      return -1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_total++;
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic emit(input logic [7:0] b, input logic fin, input logic has);
      body_result_type r;
      r.data     = b;
      r.last     = 1'b0;
      r.finished = fin;
      r.has_byte = has;
      body_expected.push_back(r);
   endtask

   task automatic hold_byte(input logic [7:0] b);
      if (held_count == 2) begin
         emit(held[0], 1'b0, 1'b1);
         held[0] = held[1];
         held[1] = b;
      end else begin
         held[held_count] = b;
         held_count++;
      end
   endtask

   task automatic clear_line();
      digit_count = 0;
      size_acc    = '0;
      plain_line  = 1'b0;
   endtask

   task automatic restart();
      mode       = LINE_SCAN;
      chunk_left = '0;
      held_count = 0;
      clear_line();
   endtask

   task automatic scan_byte(input logic [7:0] c);
      int v;
      int i;
      v = nibble_of(c);
      if (c == hcbd_pkg::CHAR_CR || c == hcbd_pkg::CHAR_LF) begin
         if (digit_count > 0 && !plain_line) begin
            held_count = 0;
            if (size_acc != 0) begin
               chunk_left = size_acc;
               mode       = SKIP_ONE;
            end else begin
               mode = BODY_DONE;
               emit(8'h00, 1'b1, 1'b0);
            end
         end else begin
            hold_byte(c);
         end
         clear_line();
      end else if (plain_line) begin
         hold_byte(c);
      end else if (v >= 0 && digit_count < DIGIT_SLOTS) begin
         digit_store[digit_count] = c;
         digit_count++;
         size_acc = (size_acc << 4) + 32'(v);
      end else begin
         // line is text after all: replay the stored digits ahead of this byte
         for (i = 0; i < digit_count; i++) begin
            hold_byte(digit_store[i]);
         end
         digit_count = 0;
         size_acc    = '0;
         hold_byte(c);
         plain_line = 1'b1;
      end
   endtask

   task automatic predict_step(input logic [7:0] c, input logic eoi);
      int first;
      int i;
      body_result_type r;
      first = body_expected.size();
      if (eoi) begin
         if (mode != BODY_DONE) begin
            for (i = 0; i < held_count; i++) begin
               emit(held[i], 1'b0, 1'b1);
            end
            if (mode == LINE_SCAN) begin
               for (i = 0; i < digit_count; i++) begin
                  emit(digit_store[i], 1'b0, 1'b1);
               end
            end
         end
         restart();
      end else begin
         case (mode)
            BODY_DONE: begin
            end
            SKIP_ONE: begin
               mode = (chunk_left != 0) ? CHUNK_PASS : LINE_SCAN;
               clear_line();
            end
            CHUNK_PASS: begin
               hold_byte(c);
               chunk_left--;
               if (chunk_left == 0) begin
                  mode = LINE_SCAN;
                  clear_line();
               end
            end
            default: begin
               scan_byte(c);
            end
         endcase
      end
      if (body_expected.size() > first) begin
         r = body_expected.pop_back();
         r.last = 1'b1;
         body_expected.push_back(r);
      end
   endtask

   task automatic check_result();
      body_result_type want;
      if (body_expected.size() == 0) begin
         report_mismatch("unexpected result", int'(rsp_tdata), -1);
      end else begin
         want = body_expected.pop_front();
         if (rsp_tdata !== want.data) begin
            report_mismatch("out_byte", int'(rsp_tdata), int'(want.data));
         end
         if (rsp_tlast !== want.last) begin
            report_mismatch("last_of_run", int'(rsp_tlast), int'(want.last));
         end
         if (rsp_tuser[0] !== want.finished) begin
            report_mismatch("finished", int'(rsp_tuser[0]), int'(want.finished));
         end
         if (rsp_tuser[1] !== want.has_byte) begin
            report_mismatch("byte_valid", int'(rsp_tuser[1]), int'(want.has_byte));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart();
         body_expected.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
         if (req_tvalid && req_tready) begin
            predict_step(req_tdata, req_tlast);
         end
      end
      expected_left  <= body_expected.size();
      mismatch_count <= fail_total;
   end

endmodule

[tb/http_chunked_body_decoder_tb.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_tb
// Feeds the chunked body decoder directed byte sequences and then random
// chunked messages, text lines, overlong and wrapping size lines, oversized
// chunks and noise, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 470;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE       = 40;

   localparam logic [7:0] CR = hcbd_pkg::CHAR_CR;
   localparam logic [7:0] LF = hcbd_pkg::CHAR_LF;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [1:0] rsp_tuser;

   int          expected_left;
   int          mismatch_count;
   int          idle_cycles = 0;
   int unsigned burst_left  = 0;
   int unsigned rx_left     = 0;
   int unsigned rx_mode     = 0;
   int          fed_items   = 0;
   bit          tail_ignored = 1'b0;

   http_chunked_body_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   http_chunked_body_decoder_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .expected_left  (expected_left),
      .mismatch_count (mismatch_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(20, 120);
      end else begin
         rx_left--;
      end
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 1) == 0);
         default: rsp_tready <= ((rx_left % 12) < 3);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("http_chunked_body_decoder test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic eoi);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 60);
      end
      burst_left--;
      if (!tail_ignored) begin
         fed_items++;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eoi;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic push_end();
      push_byte(8'($urandom_range(0, 255)), 1'b1);
      tail_ignored = 1'b0;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_left != 0);
   endtask

   function automatic logic [7:0] hex_glyph(input logic [3:0] v);
      logic [7:0] base;
      if (v < 4'd10) begin
         return 8'h30 + {4'h0, v};
      end
      base = ($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61;
      return base + {4'h0, v} - 8'd10;
   endfunction

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == CR || b == LF) ? 8'h20 : b;
   endfunction

   task automatic send_terminator(input bit as_size);
      int pick;
      pick = $urandom_range(0, 5);
      if (pick <= 3) begin
         push_byte(CR, 1'b0);
         push_byte(LF, 1'b0);
      end else begin
         push_byte((pick == 4) ? LF : CR, 1'b0);
         if (as_size) begin
            push_byte(8'($urandom_range(0, 255)), 1'b0);
         end
      end
   endtask

   task automatic send_size_line(input logic [31:0] n);
      int nd;
      int i;
      nd = 1;
      while (nd < 8 && (n >> (4 * nd)) != 0) begin
         nd++;
      end
      if ($urandom_range(0, 9) == 0) begin
         // extra top digit shifts out of the 32-bit size
         push_byte(hex_glyph(4'($urandom_range(1, 15))), 1'b0);
         nd = 8;
      end else begin
         repeat ($urandom_range(0, 2)) push_byte(8'h30, 1'b0);
      end
      for (i = nd - 1; i >= 0; i--) begin
         push_byte(hex_glyph(n[4 * i +: 4]), 1'b0);
      end
      send_terminator(1'b1);
   endtask

   task automatic send_chunk(input int n);
      send_size_line(32'(n));
      repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0);
      push_byte(CR, 1'b0);
      push_byte(LF, 1'b0);
   endtask

   task automatic send_text_line();
      push_byte(($urandom_range(0, 4) == 0) ? 8'h20 : 8'($urandom_range(8'h67, 8'h7A)), 1'b0);
      repeat ($urandom_range(0, 12)) push_byte(text_byte(), 1'b0);
      send_terminator(1'b0);
   endtask

   task automatic send_hex_run(input int count);
      repeat (count) push_byte(hex_glyph(4'($urandom_range(0, 15))), 1'b0);
   endtask

   task automatic send_message();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 5) == 0) begin
               send_text_line();
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 96) : $urandom_range(1, 16);
            send_chunk(n);
         end
         if ($urandom_range(0, 9) < 7) begin
            send_size_line(32'h0);
            tail_ignored = 1'b1;
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
         end
      end else if (pick < 70) begin
         repeat ($urandom_range(1, 3)) send_text_line();
      end else if (pick < 78) begin
         send_hex_run($urandom_range(17, 20));
         if ($urandom_range(0, 1) != 0) begin
            send_terminator(1'b0);
            send_text_line();
         end
      end else if (pick < 84) begin
         send_size_line($urandom() | 32'h8000_0000);
         repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 92) begin
         repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         send_text_line();
         send_hex_run($urandom_range(1, 16));
      end
      push_end();
   endtask

   initial begin
      int msg_count;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // end of input with nothing held
      push_byte(8'h5A, 1'b1);
      // text line of extreme bytes, then an empty line
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(LF, 1'b0);
      push_byte(LF, 1'b0);
      // text line containing a digit
      push_byte(8'h67, 1'b0);
      push_byte(8'h37, 1'b0);
      push_byte(CR, 1'b0);
      // size line, discarded byte, two-byte chunk
      push_byte(8'h32, 1'b0);
      push_byte(LF, 1'b0);
      push_byte(8'h58, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      // hex run that turns into text
      push_byte(8'h46, 1'b0);
      push_byte(8'h61, 1'b0);
      push_byte(8'h39, 1'b0);
      push_byte(8'h7A, 1'b0);
      push_byte(LF, 1'b0);
      // end of input with pending digits
      push_byte(8'h63, 1'b0);
      push_byte(8'h44, 1'b0);
      push_byte(8'hA5, 1'b1);
      // zero size on an empty holdback, ignored byte, end after finish
      push_byte(8'h30, 1'b0);
      push_byte(CR, 1'b0);
      push_byte(8'h71, 1'b0);
      push_byte(8'h00, 1'b1);

      wait_drained();

      fed_items = 0;
      msg_count = 0;
      while (fed_items < RANDOM_ITEMS) begin
         send_message();
         msg_count++;
         if (msg_count % 6 == 3) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("http_chunked_body_decoder test passed");
      end else begin
         $display("http_chunked_body_decoder test failed");
      end
      $finish;
   end

endmodule
